/* hw/rtl/assert_macros.svh */
// Assertion helpers; the including module provides clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define VT_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vertex transform check failed");

// Next-cycle implication, switched off while reset is asserted.
`define VT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vertex transform check failed");

`endif

/* hw/rtl/vt4_pkg.sv */
package vt4_pkg;

    // Default number format: signed Q16.16 in 32-bit words.
    localparam int WORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Item kinds.
    localparam logic [1:0] KIND_LOAD   = 2'd0;
    localparam logic [1:0] KIND_VECTOR = 2'd1;
    localparam logic [1:0] KIND_POINT  = 2'd2;

endpackage

/* hw/rtl/vtx_item_if.sv */
// Input channel: coefficient loads and vertices.
interface vtx_item_if #(
    parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic [1:0]                   kind;
    logic [3:0]                   coeff_index;
    logic signed [WORD_WIDTH-1:0] coeff_value;
    logic signed [WORD_WIDTH-1:0] vec_x;
    logic signed [WORD_WIDTH-1:0] vec_y;
    logic signed [WORD_WIDTH-1:0] vec_z;
    logic signed [WORD_WIDTH-1:0] vec_w;

    modport source (
        output valid, kind, coeff_index, coeff_value, vec_x, vec_y, vec_z, vec_w,
        input  ready
    );
    modport sink (
        input  valid, kind, coeff_index, coeff_value, vec_x, vec_y, vec_z, vec_w,
        output ready
    );
endinterface

/* hw/rtl/vtx_result_if.sv */
// Output channel: transformed vertices.
interface vtx_result_if #(
    parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEF
) ();
    logic                         valid;
    logic                         ready;
    logic signed [WORD_WIDTH-1:0] out_x;
    logic signed [WORD_WIDTH-1:0] out_y;
    logic signed [WORD_WIDTH-1:0] out_z;
    logic signed [WORD_WIDTH-1:0] out_w;
    logic                         divide_fault;
    logic                         overflow;

    modport source (
        output valid, out_x, out_y, out_z, out_w, divide_fault, overflow,
        input  ready
    );
    modport sink (
        input  valid, out_x, out_y, out_z, out_w, divide_fault, overflow,
        output ready
    );
endinterface

/* hw/rtl/vt4_lane.sv */
// One dot-product lane: four products, then sum, round and saturate.
module vt4_lane #(
    parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             en,
    input  logic [3:0][WORD_WIDTH-1:0]       coef,
    input  logic [3:0][WORD_WIDTH-1:0]       vec,
    output logic [WORD_WIDTH-1:0]            dot,
    output logic                             ovf
);
    localparam int PW = 2 * WORD_WIDTH;
    localparam int SW = 2 * WORD_WIDTH + 3;
    localparam logic [SW-1:0] HALF = SW'(1) << (FRAC_BITS - 1);
    localparam logic [WORD_WIDTH-1:0] MAXW = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] MINW = {1'b1, {(WORD_WIDTH-1){1'b0}}};

    logic signed [PW-1:0] prod_reg  [4];
    logic signed [PW-1:0] prod_next [4];
    logic signed [SW-1:0] sum;
    logic signed [SW-1:0] shifted;
    logic                 fits;
    logic [WORD_WIDTH-1:0] dot_reg;
    logic [WORD_WIDTH-1:0] dot_next;
    logic                  ovf_reg;
    logic                  ovf_next;

    // Exact signed products, registered before the adder.
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_next[k] = PW'($signed(coef[k])) * PW'($signed(vec[k]));
        end
    end

    // Exact sum plus half an LSB, then an arithmetic shift and saturation.
    always_comb
    begin
        sum = SW'(prod_reg[0]) + SW'(prod_reg[1]) + SW'(prod_reg[2])
            + SW'(prod_reg[3]) + $signed(HALF);
        shifted = sum >>> FRAC_BITS;
        fits = (shifted[SW-1:WORD_WIDTH-1] == '0) || (shifted[SW-1:WORD_WIDTH-1] == '1);
        if (fits)
        begin
            dot_next = shifted[WORD_WIDTH-1:0];
        end
        else
        begin
            dot_next = shifted[SW-1] ? MINW : MAXW;
        end
        ovf_next = !fits;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 4; k++)
            begin
                prod_reg[k] <= prod_next[k];
            end
            dot_reg <= dot_next;
            ovf_reg <= ovf_next;
        end
    end

    assign dot = dot_reg;
    assign ovf = ovf_reg;
endmodule

/* hw/rtl/vt4_div.sv */
// Pipelined restoring divider: (num << FRAC_BITS) / den, one quotient bit per stage.
module vt4_div #(
    parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [WORD_WIDTH-1:0] num,
    input  logic [WORD_WIDTH-1:0] den,
    output logic [WORD_WIDTH-1:0] quo,
    output logic                  ovf
);
    localparam int QW = WORD_WIDTH + FRAC_BITS;
    localparam int D  = QW;
    localparam logic [WORD_WIDTH-1:0] MAXW = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] MINW = {1'b1, {(WORD_WIDTH-1){1'b0}}};
    localparam logic [QW-1:0] MINMAG = QW'(1) << (WORD_WIDTH - 1);

    typedef struct packed {
        logic [WORD_WIDTH-1:0] rem;
        logic [QW-1:0]         nq;
        logic [WORD_WIDTH-1:0] dmag;
        logic                  neg;
        logic                  nneg;
        logic                  nzero;
        logic                  dzero;
    } div_stage_t;

    div_stage_t stage_reg [D+1];
    div_stage_t first;
    logic [QW-1:0] qmag;
    logic [WORD_WIDTH-1:0] qneg;
    logic          big;

    // One compare-and-subtract step.
    function automatic div_stage_t div_step(input div_stage_t s);
        div_stage_t r;
        logic [WORD_WIDTH:0] t;
        logic                ge;
        r  = s;
        t  = {s.rem, s.nq[QW-1]};
        ge = (t >= {1'b0, s.dmag});
        r.rem = ge ? WORD_WIDTH'(t - {1'b0, s.dmag}) : t[WORD_WIDTH-1:0];
        r.nq  = {s.nq[QW-2:0], ge};
        return r;
    endfunction

    // Magnitudes and signs go into the first stage.
    always_comb
    begin
        first.rem   = '0;
        first.nq    = {(num[WORD_WIDTH-1] ? WORD_WIDTH'(-num) : num), {FRAC_BITS{1'b0}}};
        first.dmag  = den[WORD_WIDTH-1] ? WORD_WIDTH'(-den) : den;
        first.neg   = num[WORD_WIDTH-1] ^ den[WORD_WIDTH-1];
        first.nneg  = num[WORD_WIDTH-1];
        first.nzero = (num == '0);
        first.dzero = (den == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stage_reg[0] <= first;
            for (int k = 1; k <= D; k++)
            begin
                stage_reg[k] <= div_step(stage_reg[k-1]);
            end
        end
    end

    // Sign, saturation and the zero-divisor case.
    always_comb
    begin
        qmag = stage_reg[D].nq;
        qneg = WORD_WIDTH'(-qmag);
        big  = (qmag[QW-1:WORD_WIDTH-1] != '0);
        if (stage_reg[D].dzero)
        begin
            if (stage_reg[D].nzero)
            begin
                quo = '0;
                ovf = 1'b0;
            end
            else
            begin
                quo = stage_reg[D].nneg ? MINW : MAXW;
                ovf = 1'b1;
            end
        end
        else if (stage_reg[D].neg)
        begin
            ovf = big && (qmag != MINMAG);
            quo = ovf ? MINW : qneg;
        end
        else
        begin
            ovf = big;
            quo = big ? MAXW : qmag[WORD_WIDTH-1:0];
        end
    end
endmodule

/* hw/rtl/vertex_transform_4x4_top.sv */
// Path: a transform item (Q16.16 by default) passes from its transfer through the product and sum
// registers of the dot-product lanes, the divider's input stage, its quotient-bit stages (one
// quotient bit per stage) and the output register before its result shows.
// Throughput: one item per cycle; the whole pipeline holds only while a result waits.
// Reset clears the matrix to zero, selects column-vector mode and empties the pipeline.
module vertex_transform_4x4_top #(
    parameter int WORD_WIDTH = vt4_pkg::WORD_WIDTH_DEF,
    parameter int FRAC_BITS  = vt4_pkg::FRAC_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    vtx_item_if.sink     item,
    vtx_result_if.source result,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data
);
    `include "assert_macros.svh"

    localparam int D = WORD_WIDTH + FRAC_BITS;
    localparam logic [WORD_WIDTH-1:0] MAXW = {1'b0, {(WORD_WIDTH-1){1'b1}}};
    localparam logic [WORD_WIDTH-1:0] UNIT_W =
        (FRAC_BITS >= WORD_WIDTH - 1) ? MAXW : (WORD_WIDTH'(1) << FRAC_BITS);

    typedef struct packed {
        logic                        point;
        logic                        ovf;
        logic [3:0][WORD_WIDTH-1:0]  r;
    } vt4_ctl_t;

    logic                  mode_reg;
    logic [WORD_WIDTH-1:0] matrix_reg [16];
    logic                  adv;
    logic                  take;
    logic                  load_take;
    logic                  is_xform;
    logic                  is_point;
    logic [1:0]            v_reg;
    logic [1:0]            pt_reg;
    logic [D:0]            vd_reg;
    vt4_ctl_t              ctl_reg [D+1];
    vt4_ctl_t              ctl_next;
    logic [3:0][3:0][WORD_WIDTH-1:0] coef_sel;
    logic [3:0][WORD_WIDTH-1:0]      vec;
    logic [3:0][WORD_WIDTH-1:0]      dot;
    logic [3:0]                      dot_ovf;
    logic [2:0][WORD_WIDTH-1:0]      quo;
    logic [2:0]                      quo_ovf;

    logic                  out_valid_reg;
    logic [WORD_WIDTH-1:0] out_x_reg, out_y_reg, out_z_reg, out_w_reg;
    logic                  out_fault_reg, out_ovf_reg, out_point_reg;
    logic [WORD_WIDTH-1:0] out_x_next, out_y_next, out_z_next;
    logic                  out_fault_next, out_ovf_next;

    // The pipeline moves whenever the output register is free or being emptied.
    assign adv        = !out_valid_reg || result.ready;
    assign item.ready = adv;
    assign take       = item.valid && adv;
    assign load_take  = take && (item.kind == vt4_pkg::KIND_LOAD);
    assign is_point   = (item.kind == vt4_pkg::KIND_POINT);
    assign is_xform   = (item.kind == vt4_pkg::KIND_VECTOR) || is_point;

    // Mode register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            mode_reg <= cfg_wr_data;
        end
    end

    // Coefficient store, written by load transfers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 16; i++)
            begin
                matrix_reg[i] <= '0;
            end
        end
        else if (load_take)
        begin
            matrix_reg[item.coeff_index] <= item.coeff_value;
        end
    end

    // Each lane takes a matrix row, or a column in row-vector mode.
    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                coef_sel[i][k] = mode_reg ? matrix_reg[k*4+i] : matrix_reg[i*4+k];
            end
        end
        vec[0] = item.vec_x;
        vec[1] = item.vec_y;
        vec[2] = item.vec_z;
        vec[3] = is_point ? UNIT_W : item.vec_w;
    end

    // Four dot-product lanes, one per output component.
    for (genvar g = 0; g < 4; g++)
    begin : g_lane
        vt4_lane #(
            .WORD_WIDTH (WORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk  (clk),
            .en   (adv),
            .coef (coef_sel[g]),
            .vec  (vec),
            .dot  (dot[g]),
            .ovf  (dot_ovf[g])
        );
    end

    // Three divider lanes for the perspective divide by w.
    for (genvar g = 0; g < 3; g++)
    begin : g_div
        vt4_div #(
            .WORD_WIDTH (WORD_WIDTH),
            .FRAC_BITS  (FRAC_BITS)
        ) u_div (
            .clk (clk),
            .en  (adv),
            .num (dot[g]),
            .den (dot[3]),
            .quo (quo[g]),
            .ovf (quo_ovf[g])
        );
    end

    // Valid and side data run alongside the lanes and the divider stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg  <= '0;
            vd_reg <= '0;
        end
        else if (adv)
        begin
            v_reg  <= {v_reg[0], take && is_xform};
            vd_reg <= {vd_reg[D-1:0], v_reg[1]};
        end
    end

    always_comb
    begin
        ctl_next.point = pt_reg[1];
        ctl_next.ovf   = |dot_ovf;
        ctl_next.r     = dot;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pt_reg     <= {pt_reg[0], is_point};
            ctl_reg[0] <= ctl_next;
            for (int k = 1; k <= D; k++)
            begin
                ctl_reg[k] <= ctl_reg[k-1];
            end
        end
    end

    // Merge: pick quotients in point mode, and gather the flags.
    always_comb
    begin
        if (ctl_reg[D].point)
        begin
            out_x_next     = quo[0];
            out_y_next     = quo[1];
            out_z_next     = quo[2];
            out_fault_next = (ctl_reg[D].r[3] == '0);
            out_ovf_next   = ctl_reg[D].ovf || (|quo_ovf);
        end
        else
        begin
            out_x_next     = ctl_reg[D].r[0];
            out_y_next     = ctl_reg[D].r[1];
            out_z_next     = ctl_reg[D].r[2];
            out_fault_next = 1'b0;
            out_ovf_next   = ctl_reg[D].ovf;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= vd_reg[D];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_x_reg     <= out_x_next;
            out_y_reg     <= out_y_next;
            out_z_reg     <= out_z_next;
            out_w_reg     <= ctl_reg[D].r[3];
            out_fault_reg <= out_fault_next;
            out_ovf_reg   <= out_ovf_next;
            out_point_reg <= ctl_reg[D].point;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.out_x        = out_x_reg;
    assign result.out_y        = out_y_reg;
    assign result.out_z        = out_z_reg;
    assign result.out_w        = out_w_reg;
    assign result.divide_fault = out_fault_reg;
    assign result.overflow     = out_ovf_reg;

    // A load transfer lands in the addressed coefficient.
    `VT_ASSERT_NEXT(a_load_writes, load_take, matrix_reg[$past(item.coeff_index)] == $past(item.coeff_value))
    // A divide fault only comes from point mode with a zero w.
    `VT_ASSERT_NOW(a_fault_point, out_valid_reg && out_fault_reg, out_point_reg && (out_w_reg == '0))
    // A divide fault with a non-zero x component always saturates.
    `VT_ASSERT_NOW(a_fault_ovf, out_valid_reg && out_fault_reg && (out_x_reg != '0), out_ovf_reg)
endmodule
